FILE: sv/sct_pkg.sv
// Package: shared constants, types and helpers for the sine/cosine unit.
`timescale 1ns / 1ps
`default_nettype none
package sct_pkg;
    localparam int TERMS_DEF = 10;
    localparam int FRAC_BITS_DEF = 24;
    localparam int WORK_BITS = 52;
    localparam int TW = 64;
    localparam logic [63:0] TWO_PI_Q60 = 64'h6487ED5110B4611A;

    typedef enum logic {
        OP_SIN = 1'b0,
        OP_COS = 1'b1
    } t_op;

    function automatic logic [33:0] two_pi(input int fb);
        logic [63:0] v;
        begin
            v = (TWO_PI_Q60 + (64'd1 << (59 - fb))) >> (60 - fb);
            return v[33:0];
        end
    endfunction

    // ceil(2^(62+clog2(k)) / k): floor(y / k) == (y * m) >> (62+clog2(k)) for y < 2^62
    function automatic logic [63:0] recip_k(input int k);
        logic [127:0] num;
        int           l;
        begin
            l   = $clog2(k);
            num = 128'd1 << (62 + l);
            return 64'((num + 128'(k) - 128'd1) / 128'(k));
        end
    endfunction
endpackage
`default_nettype wire

FILE: sv/sct_if.sv
// Interfaces: valid/ready channels for angle items and result items.
`timescale 1ns / 1ps
`default_nettype none
interface sct_in_if;
    logic               valid;
    logic               ready;
    logic               operation;
    logic signed [31:0] angle;
    modport source (output valid, operation, angle, input ready);
    modport sink   (input valid, operation, angle, output ready);
endinterface

interface sct_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] value;
    logic               saturated;
    modport source (output valid, value, saturated, input ready);
    modport sink   (input valid, value, saturated, output ready);
endinterface
`default_nettype wire

FILE: sv/sine_cosine_taylor.sv
// Top level: pipelined sine/cosine by truncated Taylor series.
// Usage:
//  - in_ch (sink): operation (0 sine, 1 cosine) and angle in signed Q8.24.
//  - out_ch (source): value, the series sum in Q8.24 saturated, and the
//    saturated flag.
//  - One item per cycle sustained while the receiver does not stall; every
//    stage advances together on a global enable.
//  - Reduction into -2pi..2pi is a remainder by a constant, done as a
//    multiply by a reciprocal and a single correction step (4 stages).
//  - Each Taylor step takes four stages: t * a partial products, combine,
//    reciprocal partial products for the divide by k, then sum and
//    accumulate. 2*TERMS steps cover sine and cosine; one final stage
//    rounds, signs and saturates.
//  - When the receiver stalls and the last stage holds a result, the whole
//    pipe freezes; input ready drops. Nothing is lost or repeated.
//  - Reset clears all valid bits; payload registers are not reset.
`timescale 1ns / 1ps
`default_nettype none
module sine_cosine_taylor
    import sct_pkg::*;
#(
    parameter int TERMS = TERMS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input wire logic i_clk,
    input wire logic i_rst_n,
    sct_in_if.sink    in_ch,
    sct_out_if.source out_ch
);
    localparam int STEPS = 2 * TERMS;
    localparam int DEPTH = 5 + 4 * STEPS;
    localparam logic [33:0] TP = two_pi(FRAC_BITS);
    // reciprocal of 2pi scaled by 2^RSH; stays below 2^32
    localparam int RSH = FRAC_BITS + 34;
    localparam logic [31:0] RECIP = 32'((128'd1 << RSH) / {94'd0, TP});

    logic en;
    logic [DEPTH-1:0] r_vld;

    assign en = !r_vld[DEPTH-1] || out_ch.ready;
    assign in_ch.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_vld <= '0;
        else if (en)
            r_vld <= {r_vld[DEPTH-2:0], in_ch.valid};
    end

    // control travels with data: cosine flag, sign of the angle
    logic [DEPTH-2:0] r_cos;
    logic [DEPTH-2:0] r_neg;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cos <= {r_cos[DEPTH-3:0], (t_op'(in_ch.operation) == OP_COS)};
            r_neg <= {r_neg[DEPTH-3:0], in_ch.angle[31]};
        end
    end

    // stage 0: magnitude-minus-one and reduce decision
    logic [32:0] r0_m;
    logic        r0_red;
    logic signed [32:0] r0_x;
    logic [32:0] n0_m;
    logic signed [32:0] n0_x;
    always_comb begin
        n0_x = {in_ch.angle[31], in_ch.angle};
        n0_m = in_ch.angle[31] ? 33'(-n0_x) - 33'd1 : 33'(n0_x) - 33'd1;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r0_x   <= n0_x;
            r0_m   <= n0_m;
            r0_red <= (n0_x > $signed({1'b0, 32'(TP)})) || (n0_x < -$signed({1'b0, 32'(TP)}));
        end
    end

    // stage 1: quotient estimate by reciprocal
    logic [63:0] r1_q;
    logic [32:0] r1_m;
    logic        r1_red;
    logic signed [32:0] r1_x;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_q   <= {32'd0, r0_m[31:0]} * {32'd0, RECIP};
            r1_m   <= r0_m;
            r1_red <= r0_red;
            r1_x   <= r0_x;
        end
    end

    // stage 2: remainder estimate
    logic [32:0] r2_rem;
    logic        r2_red;
    logic signed [32:0] r2_x;
    logic [32:0] n2_q;
    always_comb n2_q = 33'(r1_q >> RSH);
    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_rem <= 33'(r1_m - 33'(n2_q * 33'(TP)));
            r2_red <= r1_red;
            r2_x   <= r1_x;
        end
    end

    // stage 3: correction, form magnitude a; the estimate is low by at most 1
    logic [32:0] n3_r;
    logic [31:0] r3_a;
    always_comb begin
        n3_r = r2_rem;
        if (n3_r >= 33'(TP)) n3_r = n3_r - 33'(TP);
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_a <= r2_red ? 32'(n3_r + 33'd1)
                           : (r2_x[32] ? 32'(-r2_x) : 32'(r2_x));
        end
    end

    // series stages
    logic [TW-1:0] t_ch [0:STEPS];
    logic signed [TW-1:0] s_ch [0:STEPS];
    logic [31:0] a_ch [0:STEPS];
    assign t_ch[0] = TW'(1) << WORK_BITS;
    assign s_ch[0] = r_cos[3] ? $signed(TW'(1) << WORK_BITS) : '0;
    assign a_ch[0] = r3_a;

    for (genvar g = 0; g < STEPS; g++) begin : g_step
        logic [31:0] r_a [0:3];
        sct_term_stage #(
            .FRAC_BITS(FRAC_BITS),
            .K(g + 1),
            .N((g + 1) / 2),
            .ADD(((g + 1) / 2) < TERMS || (g % 2 == 0))
        ) u_term (
            .i_clk(i_clk),
            .i_en (en),
            .i_t  (t_ch[g]),
            .i_a  (a_ch[g]),
            .i_sum(s_ch[g]),
            .i_cos(r_cos[3 + 4 * g]),
            .o_t  (t_ch[g + 1]),
            .o_sum(s_ch[g + 1])
        );
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_a[0] <= a_ch[g];
                r_a[1] <= r_a[0];
                r_a[2] <= r_a[1];
                r_a[3] <= r_a[2];
            end
        end
        assign a_ch[g + 1] = r_a[3];
    end

    // final stage: round, sign, saturate
    localparam int SH = WORK_BITS - FRAC_BITS;
    logic signed [TW-1:0] fs;
    logic          fneg;
    logic [TW-1:0] fmag;
    logic [TW-1:0] fq;
    logic signed [TW:0] fres;
    logic [31:0]   r_val;
    logic          r_sat;
    always_comb begin
        fs   = s_ch[STEPS];
        fneg = fs < 0;
        fmag = fneg ? TW'(-fs) : TW'(fs);
        fq   = (fmag + (TW'(1) << (SH - 1))) >> SH;
        if (!r_cos[DEPTH-2] && r_neg[DEPTH-2]) fneg = !fneg;
        fres = fneg ? -$signed({1'b0, fq}) : $signed({1'b0, fq});
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            if (fres > 65'sh7FFFFFFF) begin
                r_val <= 32'h7FFFFFFF; r_sat <= 1'b1;
            end else if (fres < -65'sh80000000) begin
                r_val <= 32'h80000000; r_sat <= 1'b1;
            end else begin
                r_val <= fres[31:0]; r_sat <= 1'b0;
            end
        end
    end
    assign out_ch.valid     = r_vld[DEPTH-1];
    assign out_ch.value     = r_val;
    assign out_ch.saturated = r_sat;
endmodule
`default_nettype wire

FILE: sv/sct_term_stage.sv
// One series step: t_k = floor(floor(t * a / 2^FRAC_BITS) / k), with add into sum.
`timescale 1ns / 1ps
`default_nettype none
module sct_term_stage
    import sct_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int K = 1,
    parameter int N = 0,
    parameter bit ADD = 1'b0
) (
    input  wire logic          i_clk,
    input  wire logic          i_en,
    input  wire logic [TW-1:0] i_t,
    input  wire logic [31:0]   i_a,
    input  wire logic signed [TW-1:0] i_sum,
    input  wire logic          i_cos,
    output logic [TW-1:0]      o_t,
    output logic signed [TW-1:0] o_sum
);
    // term is added when its index matches 2n (cos) or 2n+1 (sin)
    localparam int KC = 2 * N;
    localparam int KS = 2 * N + 1;
    // divide by K as a reciprocal multiply; exact while t * a / 2^FRAC_BITS < 2^62
    localparam int QSH = 62 + $clog2(K);
    localparam logic [63:0] M = recip_k(K);

    logic [TW-1:0] r_hi;
    logic [TW-1:0] r_lo;
    logic signed [TW-1:0] r_sum_a;
    logic          r_cos_a;
    logic [TW-1:0] r_y;
    logic signed [TW-1:0] r_sum_b;
    logic          r_cos_b;
    logic [TW-1:0] r_ll;
    logic [TW-1:0] r_lh;
    logic [TW-1:0] r_hl;
    logic [TW-1:0] r_hh;
    logic signed [TW-1:0] r_sum_c;
    logic          r_cos_c;
    logic [TW-1:0] n_prod;
    logic [2*TW-1:0] n_full;
    logic [TW-1:0] n_t;
    logic          n_take;

    // stage A: two 32x32 partial products of t * a
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_hi    <= {32'd0, i_t[63:32]} * {32'd0, i_a};
            r_lo    <= {32'd0, i_t[31:0]} * {32'd0, i_a};
            r_sum_a <= i_sum;
            r_cos_a <= i_cos;
        end
    end

    // stage B: combine and drop fraction bits
    always_comb n_prod = (r_hi << (32 - FRAC_BITS)) + (r_lo >> FRAC_BITS);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_y     <= n_prod;
            r_sum_b <= r_sum_a;
            r_cos_b <= r_cos_a;
        end
    end

    // stage C: four 32x32 partial products of y * reciprocal
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ll    <= {32'd0, r_y[31:0]} * {32'd0, M[31:0]};
            r_lh    <= {32'd0, r_y[31:0]} * {32'd0, M[63:32]};
            r_hl    <= {32'd0, r_y[63:32]} * {32'd0, M[31:0]};
            r_hh    <= {32'd0, r_y[63:32]} * {32'd0, M[63:32]};
            r_sum_c <= r_sum_b;
            r_cos_c <= r_cos_b;
        end
    end

    // stage D: sum partials, take quotient, accumulate
    always_comb begin
        n_full = {r_hh, 64'd0} + {32'd0, r_lh, 32'd0} + {32'd0, r_hl, 32'd0}
                 + {64'd0, r_ll};
        n_t    = TW'(n_full >> QSH);
        n_take = ADD && ((r_cos_c && (K == KC)) || (!r_cos_c && (K == KS)));
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_t <= n_t;
            if (n_take)
                o_sum <= (N % 2 == 1) ? r_sum_c - $signed(n_t) : r_sum_c + $signed(n_t);
            else
                o_sum <= r_sum_c;
        end
    end
endmodule
`default_nettype wire

FILE: sv/sct_checker.sv
// Checker: port-level properties of the sine/cosine unit, bound to the top.
`timescale 1ns / 1ps
`default_nettype none
module sct_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [31:0] out_value,
    input wire logic        out_saturated
);
    a_rst_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !out_valid)
        else $error("output valid after reset");
    a_stall_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_valid && !out_ready) |-> !in_ready)
        else $error("input taken while output stalled");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_value)))
        else $error("stalled result changed");
    a_sat_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_valid && out_saturated) |->
        (out_value == 32'h7FFFFFFF || out_value == 32'h80000000))
        else $error("saturated value not at range end");
endmodule

bind sine_cosine_taylor sct_checker u_sct_checker (
    .i_clk(i_clk),
    .i_rst_n(i_rst_n),
    .in_valid(in_ch.valid),
    .in_ready(in_ch.ready),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .out_value(out_ch.value),
    .out_saturated(out_ch.saturated)
);
`default_nettype wire

FILE: tb/tb_top.sv
// Testbench: sine/cosine Taylor unit checked against a bit-exact predictor.
`timescale 1ns / 1ps
module tb_top;
    import sct_pkg::*;

    localparam int N_TERMS   = 10;
    localparam int FB        = 24;
    localparam int WB        = 52;
    localparam int LATENCY   = 4 + 4 * (2 * N_TERMS);
    localparam int WDOG_MAX  = 20000;
    localparam int N_RANDOM  = 1030;

    typedef struct packed {
        t_op         op;
        logic [31:0] angle;
    } angle_item_t;

    typedef struct packed {
        logic [31:0] value;
        logic        sat;
    } trig_result_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    sct_in_if  in_ch ();
    sct_out_if out_ch ();

    sine_cosine_taylor #(.TERMS(N_TERMS), .FRAC_BITS(FB)) u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    always #1 i_clk = ~i_clk;

    angle_item_t  pending_angles[$];
    trig_result_t expected_trig[$];
    int  n_errors = 0;
    bit  stim_done = 1'b0;
    bit  sender_hold = 1'b0;   // sender pause, set once drained
    bit  no_idle = 1'b0;       // stretch with no idling on either side
    int  recv_hold = 0;        // long receiver hold-off, in cycles
    int  wdog = 0;

    // 2pi at FB fraction bits, rounded half up
    function automatic longint two_pi_q();
        logic [63:0] c;
        c = (64'h6487ED5110B4611A + (64'd1 << (59 - FB))) >> (60 - FB);
        return longint'(c);
    endfunction

    // Truncated Taylor sum, rounded and saturated
    function automatic trig_result_t predict_trig(angle_item_t it);
        longint      x, tp, r, sum, q;
        logic [63:0] a, t, mag, hi, lo;
        bit          neg;
        int          k, target;
        trig_result_t res;
        x  = longint'($signed(it.angle));
        tp = two_pi_q();
        if (x > tp) r = ((x - 1) % tp) + 1;
        else if (x < -tp) r = -(((-x - 1) % tp) + 1);
        else r = x;
        a = (r < 0) ? 64'(-r) : 64'(r);
        t = 64'd1 << WB;
        k = 0;
        sum = 0;
        for (int n = 0; n < N_TERMS; n++) begin
            target = 2 * n + ((it.op == OP_COS) ? 0 : 1);
            while (k < target) begin
                k++;
                hi = (t >> 32) * a;
                lo = (t & 64'hFFFF_FFFF) * a;
                t = ((hi << (32 - FB)) + (lo >> FB)) / 64'(k);
            end
            if (n % 2 == 1) sum -= longint'(t);
            else sum += longint'(t);
        end
        neg = sum < 0;
        mag = neg ? 64'(-sum) : 64'(sum);
        mag = (mag + (64'd1 << (WB - FB - 1))) >> (WB - FB);
        q = longint'(mag);
        if (it.op == OP_SIN && r < 0) neg = !neg;
        if (neg) q = -q;
        res.sat = 1'b0;
        if (q > 64'sh7FFF_FFFF) begin
            q = 64'sh7FFF_FFFF;
            res.sat = 1'b1;
        end else if (q < -64'sh8000_0000) begin
            q = -64'sh8000_0000;
            res.sat = 1'b1;
        end
        res.value = q[31:0];
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        n_errors++;
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    endtask

    function automatic bit idle_roll();
        return !no_idle && ($urandom_range(99) < 37);
    endfunction

    // Driver: offers the head of the queue; valid stays up until accepted
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                expected_trig.push_back(predict_trig({in_ch.operation, in_ch.angle}));
                void'(pending_angles.pop_front());
            end
            if (in_ch.valid && !in_ch.ready) begin
                // hold the offered item
            end else if (pending_angles.size() > (in_ch.valid && in_ch.ready ? 0 : 0)
                         && !sender_hold && !idle_roll()) begin
                in_ch.valid     <= 1'b1;
                in_ch.operation <= pending_angles[0].op;
                in_ch.angle     <= pending_angles[0].angle;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // Monitor: checks each accepted result, drives ready
    always @(posedge i_clk) begin
        trig_result_t want;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (expected_trig.size() == 0) begin
                    report_mismatch("unexpected result", out_ch.value, 32'h0);
                end else begin
                    want = expected_trig.pop_front();
                    if (out_ch.value !== want.value)
                        report_mismatch("value", out_ch.value, want.value);
                    if (out_ch.saturated !== want.sat)
                        report_mismatch("saturated", 32'(out_ch.saturated), 32'(want.sat));
                end
            end
            if (recv_hold > 0) begin
                recv_hold <= recv_hold - 1;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= !idle_roll();
            end
        end
    end

    // Watchdog: cycles with nothing accepted on either side
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
            || (pending_angles.size() == 0 && expected_trig.size() == 0))
            wdog <= 0;
        else
            wdog <= wdog + 1;
        if (wdog >= WDOG_MAX) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic add_angle(t_op op, logic [31:0] ang);
        angle_item_t it;
        it.op = op;
        it.angle = ang;
        pending_angles.push_back(it);
    endtask

    // angles mostly within a few turns, some anywhere in the range
    function automatic logic [31:0] rand_angle();
        int sel;
        sel = $urandom_range(9);
        if (sel < 5) return 32'($signed($urandom_range(0, 32'h0C00_0000)) - 32'sh0600_0000);
        if (sel < 7) return 32'($signed($urandom_range(0, 32'h3000_0000)) - 32'sh1800_0000);
        return $urandom();
    endfunction

    initial begin
        longint tp;
        in_ch.valid = 1'b0;
        in_ch.operation = 1'b0;
        in_ch.angle = '0;
        out_ch.ready = 1'b0;
        tp = two_pi_q();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: field extremes, both operations, exact +-2pi and neighbors
        for (int o = 0; o < 2; o++) begin
            add_angle(t_op'(o), 32'h0000_0000);
            add_angle(t_op'(o), 32'h7FFF_FFFF);
            add_angle(t_op'(o), 32'h8000_0000);
            add_angle(t_op'(o), 32'(tp));
            add_angle(t_op'(o), 32'(-tp));
            add_angle(t_op'(o), 32'(tp + 1));
            add_angle(t_op'(o), 32'(-tp - 1));
            add_angle(t_op'(o), 32'(tp - 1));
            add_angle(t_op'(o), 32'hFFFF_FFFF);
            add_angle(t_op'(o), 32'h0000_0001);
        end
        // wait for drain, a sender pause with everything delivered
        wait (pending_angles.size() == 0 && expected_trig.size() == 0);
        sender_hold <= 1'b1;
        repeat (LATENCY + 5) @(posedge i_clk);
        sender_hold <= 1'b0;

        // long receiver hold-off while the sender keeps offering
        for (int i = 0; i < 150; i++) add_angle(t_op'($urandom_range(1)), rand_angle());
        recv_hold <= 3 * LATENCY;
        wait (pending_angles.size() == 0);

        // stretch with no idling
        no_idle <= 1'b1;
        for (int i = 0; i < 200; i++) add_angle(t_op'($urandom_range(1)), rand_angle());
        wait (pending_angles.size() == 0);
        no_idle <= 1'b0;

        for (int i = 0; i < N_RANDOM - 350; i++)
            add_angle(t_op'($urandom_range(1)), rand_angle());
        wait (pending_angles.size() == 0 && expected_trig.size() == 0);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (n_errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
